### rtl/core/tcfs_pkg.sv
package tcfs_pkg;

	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 16;
	localparam int LIGHT_W     = 16;
	localparam int LEVEL_W     = 9;
	localparam int COLOR_W     = 8;
	localparam int QUOT_W      = 17;
	localparam int INTEN_FRAC  = 14;
	localparam int SHADE_SHIFT = 22;
	localparam int NORM_BITS   = 30;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LIGHT_X = 3'd0,
		REG_LIGHT_Y = 3'd1,
		REG_LIGHT_Z = 3'd2,
		REG_AMBIENT = 3'd3,
		REG_DIFFUSE = 3'd4
	} cfg_reg_t;

	localparam logic signed [LIGHT_W-1:0] LIGHT_X_RST = 16'sd5959;
	localparam logic signed [LIGHT_W-1:0] LIGHT_Y_RST = -16'sd11917;
	localparam logic signed [LIGHT_W-1:0] LIGHT_Z_RST = -16'sd9534;
	localparam logic [LEVEL_W-1:0]        AMBIENT_RST = 9'd38;
	localparam logic [LEVEL_W-1:0]        DIFFUSE_RST = 9'd218;

endpackage

### rtl/core/triangle_cull_and_flat_shade.sv
// Back-face cull and flat Lambert shade, one triangle per request. A triangle may enter
// every cycle while tri_ready is high. N is the width of the block-scaled normal
// (31 for COORD_WIDTH 16, fewer for narrow coordinates): the normal length goes
// through a one-bit-per-stage square root of N stages and the intensity through a
// 17-stage restoring divider. Culled triangles leave a bubble and produce no result.
// An output register plus one skid entry let a new triangle enter while a result waits;
// tri_ready drops only when both are full. Light and shade registers are sampled in
// flight, so write them only while the pipeline is empty.
module triangle_cull_and_flat_shade #(
	parameter int COORD_WIDTH = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [tcfs_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [tcfs_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                 tri_valid,
	output logic                                 tri_ready,
	input  logic signed [COORD_WIDTH-1:0]        ax,
	input  logic signed [COORD_WIDTH-1:0]        ay,
	input  logic signed [COORD_WIDTH-1:0]        az,
	input  logic signed [COORD_WIDTH-1:0]        bx,
	input  logic signed [COORD_WIDTH-1:0]        by_coord,
	input  logic signed [COORD_WIDTH-1:0]        bz,
	input  logic signed [COORD_WIDTH-1:0]        cx,
	input  logic signed [COORD_WIDTH-1:0]        cy,
	input  logic signed [COORD_WIDTH-1:0]        cz,
	input  logic [tcfs_pkg::COLOR_W-1:0]         base_red,
	input  logic [tcfs_pkg::COLOR_W-1:0]         base_green,
	input  logic [tcfs_pkg::COLOR_W-1:0]         base_blue,
	output logic                                 res_valid,
	input  logic                                 res_ready,
	output logic [tcfs_pkg::COLOR_W-1:0]         lit_red,
	output logic [tcfs_pkg::COLOR_W-1:0]         lit_green,
	output logic [tcfs_pkg::COLOR_W-1:0]         lit_blue,
	output logic signed [COORD_WIDTH-1:0]        mean_depth
);

	import tcfs_pkg::*;

	localparam int PS   = COORD_WIDTH > 16 ? COORD_WIDTH - 16 : 0;
	localparam int EW   = COORD_WIDTH + 1 - PS;
	localparam int AW   = COORD_WIDTH - PS;
	localparam int PW   = 2 * EW;
	localparam int NW   = PW + 1;
	localparam int FW   = NW + AW;
	localparam int SW   = FW + 2;
	localparam int N1W  = NW > NORM_BITS + 1 ? NORM_BITS + 1 : NW;
	localparam int KMAX = NW > NORM_BITS ? NW - NORM_BITS : 1;
	localparam int KW   = $clog2(KMAX + 1);
	localparam int L2W  = 2 * N1W;
	localparam int RW   = N1W;
	localparam int LPW  = N1W + LIGHT_W;
	localparam int DW   = LPW + 2;
	localparam int DMW  = COORD_WIDTH + 1;
	localparam int D3W  = 2 * DMW + 1;
	localparam logic [DMW:0] D3M = (DMW + 1)'(((64'd1 << (DMW + 1)) + 64'd2) / 64'd3);
	localparam int SHW  = ((LEVEL_W + INTEN_FRAC > LEVEL_W + QUOT_W) ?
		LEVEL_W + INTEN_FRAC : LEVEL_W + QUOT_W) + 1;
	localparam int PRW  = COLOR_W + SHW;
	localparam int SIDE_W = 3 * COLOR_W + 1 + DMW;

	typedef struct packed {
		logic [COLOR_W-1:0]     red;
		logic [COLOR_W-1:0]     green;
		logic [COLOR_W-1:0]     blue;
		logic [COORD_WIDTH-1:0] depth;
	} res_t;

	// configuration
	logic signed [LIGHT_W-1:0] light_q [3];
	logic [LEVEL_W-1:0]        amb_q;
	logic [LEVEL_W-1:0]        gain_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			light_q[0] <= LIGHT_X_RST;
			light_q[1] <= LIGHT_Y_RST;
			light_q[2] <= LIGHT_Z_RST;
			amb_q      <= AMBIENT_RST;
			gain_q     <= DIFFUSE_RST;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_LIGHT_X: light_q[0] <= cfg_data;
				REG_LIGHT_Y: light_q[1] <= cfg_data;
				REG_LIGHT_Z: light_q[2] <= cfg_data;
				REG_AMBIENT: amb_q      <= cfg_data[LEVEL_W-1:0];
				REG_DIFFUSE: gain_q     <= cfg_data[LEVEL_W-1:0];
				default: ;
			endcase
		end
	end

	logic en;
	logic skid_v_q;
	logic out_v_q;

	assign en        = !skid_v_q;
	assign tri_ready = en;

	// s1: edges, prescaled first vertex, depth sum
	logic signed [COORD_WIDTH-1:0] va [3];
	logic signed [COORD_WIDTH-1:0] vb [3];
	logic signed [COORD_WIDTH-1:0] vc [3];
	logic [COORD_WIDTH:0]          d1 [3];
	logic [COORD_WIDTH:0]          d2 [3];
	logic signed [COORD_WIDTH+1:0] dsum;

	assign va[0] = ax;
	assign va[1] = ay;
	assign va[2] = az;
	assign vb[0] = bx;
	assign vb[1] = by_coord;
	assign vb[2] = bz;
	assign vc[0] = cx;
	assign vc[1] = cy;
	assign vc[2] = cz;
	assign dsum  = az + bz + cz;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			d1[k] = {vb[k][COORD_WIDTH-1], vb[k]} - {va[k][COORD_WIDTH-1], va[k]};
			d2[k] = {vc[k][COORD_WIDTH-1], vc[k]} - {va[k][COORD_WIDTH-1], va[k]};
		end
	end

	logic                          v_s1;
	logic signed [EW-1:0]          e1_s1 [3];
	logic signed [EW-1:0]          e2_s1 [3];
	logic signed [AW-1:0]          a_s1  [3];
	logic signed [COORD_WIDTH+1:0] dsum_s1;
	logic [2:0][COLOR_W-1:0]       col_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				e1_s1[k] <= d1[k][COORD_WIDTH:PS];
				e2_s1[k] <= d2[k][COORD_WIDTH:PS];
				a_s1[k]  <= va[k][COORD_WIDTH-1:PS];
			end
			dsum_s1 <= dsum;
			col_s1  <= {base_red, base_green, base_blue};
		end
	end

	// s2: cross product terms, depth magnitude
	logic                    v_s2;
	logic signed [PW-1:0]    p_s2 [6];
	logic signed [AW-1:0]    a_s2 [3];
	logic                    dneg_s2;
	logic [DMW-1:0]          dmag_s2;
	logic [2:0][COLOR_W-1:0] col_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			p_s2[0] <= e1_s1[1] * e2_s1[2];
			p_s2[1] <= e1_s1[2] * e2_s1[1];
			p_s2[2] <= e1_s1[2] * e2_s1[0];
			p_s2[3] <= e1_s1[0] * e2_s1[2];
			p_s2[4] <= e1_s1[0] * e2_s1[1];
			p_s2[5] <= e1_s1[1] * e2_s1[0];
			a_s2    <= a_s1;
			dneg_s2 <= dsum_s1[COORD_WIDTH+1];
			dmag_s2 <= dsum_s1[COORD_WIDTH+1] ? DMW'(-dsum_s1) : DMW'(dsum_s1);
			col_s2  <= col_s1;
		end
	end

	// s3: normal, depth divided by three
	logic [D3W-1:0] d3p;

	assign d3p = D3W'(dmag_s2) * D3W'(D3M);

	logic                    v_s3;
	logic signed [NW-1:0]    n_s3 [3];
	logic signed [AW-1:0]    a_s3 [3];
	logic                    dneg_s3;
	logic [DMW-1:0]          dq_s3;
	logic [2:0][COLOR_W-1:0] col_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				n_s3[k] <= NW'(p_s2[2*k]) - NW'(p_s2[2*k+1]);
			end
			a_s3    <= a_s2;
			dneg_s3 <= dneg_s2;
			dq_s3   <= d3p[D3W-1:DMW+1];
			col_s3  <= col_s2;
		end
	end

	// s4: facing terms, largest normal magnitude
	logic [NW-1:0] nmag [3];
	logic [NW-1:0] nmax;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			nmag[k] = n_s3[k][NW-1] ? NW'(-n_s3[k]) : NW'(n_s3[k]);
		end
		nmax = nmag[0];
		if (nmag[1] > nmax) begin
			nmax = nmag[1];
		end
		if (nmag[2] > nmax) begin
			nmax = nmag[2];
		end
	end

	logic                    v_s4;
	logic signed [FW-1:0]    f_s4 [3];
	logic signed [NW-1:0]    n_s4 [3];
	logic [NW-1:0]           mag_s4;
	logic                    dneg_s4;
	logic [DMW-1:0]          dq_s4;
	logic [2:0][COLOR_W-1:0] col_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				f_s4[k] <= n_s3[k] * a_s3[k];
			end
			n_s4    <= n_s3;
			mag_s4  <= nmax;
			dneg_s4 <= dneg_s3;
			dq_s4   <= dq_s3;
			col_s4  <= col_s3;
		end
	end

	// s5: cull decision, block scale shift
	logic signed [SW-1:0] fsum;
	logic [KW-1:0]        kshift;

	assign fsum = f_s4[0] + f_s4[1] + f_s4[2];

	always_comb begin
		kshift = '0;
		for (int b = NORM_BITS; b < NW; b++) begin
			if (mag_s4[b]) begin
				kshift = KW'(b - NORM_BITS + 1);
			end
		end
	end

	logic                    v_s5;
	logic signed [NW-1:0]    n_s5 [3];
	logic [KW-1:0]           k_s5;
	logic                    dneg_s5;
	logic [DMW-1:0]          dq_s5;
	logic [2:0][COLOR_W-1:0] col_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			n_s5    <= n_s4;
			k_s5    <= kshift;
			dneg_s5 <= dneg_s4;
			dq_s5   <= dq_s4;
			col_s5  <= col_s4;
		end
	end

	// s6: scaled normal
	logic                    v_s6;
	logic signed [N1W-1:0]   np_s6 [3];
	logic                    dneg_s6;
	logic [DMW-1:0]          dq_s6;
	logic [2:0][COLOR_W-1:0] col_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				np_s6[k] <= N1W'(n_s5[k] >>> k_s5);
			end
			dneg_s6 <= dneg_s5;
			dq_s6   <= dq_s5;
			col_s6  <= col_s5;
		end
	end

	// s7: squares and light terms
	logic                    v_s7;
	logic [L2W-1:0]          sq_s7 [3];
	logic signed [LPW-1:0]   lp_s7 [3];
	logic                    dneg_s7;
	logic [DMW-1:0]          dq_s7;
	logic [2:0][COLOR_W-1:0] col_s7;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				sq_s7[k] <= $unsigned(L2W'(np_s6[k] * np_s6[k]));
				lp_s7[k] <= np_s6[k] * light_q[k];
			end
			dneg_s7 <= dneg_s6;
			dq_s7   <= dq_s6;
			col_s7  <= col_s6;
		end
	end

	// square root stages
	logic                    sv_s   [RW+1];
	logic [L2W-1:0]          rad_s  [RW+1];
	logic [L2W-1:0]          root_s [RW+1];
	logic signed [DW-1:0]    dot_s  [RW+1];
	logic [DMW-1:0]          dq_s   [RW+1];
	logic                    dn_s   [RW+1];
	logic [2:0][COLOR_W-1:0] col_s  [RW+1];

	always_ff @(posedge clk) begin
		if (en) begin
			rad_s[0]  <= sq_s7[0] + sq_s7[1] + sq_s7[2];
			root_s[0] <= '0;
			dot_s[0]  <= lp_s7[0] + lp_s7[1] + lp_s7[2];
			dq_s[0]   <= dq_s7;
			dn_s[0]   <= dneg_s7;
			col_s[0]  <= col_s7;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			v_s3     <= 1'b0;
			v_s4     <= 1'b0;
			v_s5     <= 1'b0;
			v_s6     <= 1'b0;
			v_s7     <= 1'b0;
			sv_s[0]  <= 1'b0;
		end else if (en) begin
			v_s1     <= tri_valid;
			v_s2     <= v_s1;
			v_s3     <= v_s2;
			v_s4     <= v_s3;
			v_s5     <= v_s4 && !(fsum > 0);
			v_s6     <= v_s5;
			v_s7     <= v_s6;
			sv_s[0]  <= v_s7;
		end
	end

	for (genvar i = 0; i < RW; i++) begin : g_sqrt
		localparam int BP = 2 * (RW - 1 - i);
		logic [L2W-1:0] trial;
		logic           take;

		assign trial = root_s[i] + (L2W'(1) << BP);
		assign take  = rad_s[i] >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sv_s[i+1] <= 1'b0;
			end else if (en) begin
				sv_s[i+1] <= sv_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[i+1]  <= take ? rad_s[i] - trial : rad_s[i];
				root_s[i+1] <= take ? (root_s[i] >> 1) + (L2W'(1) << BP) : root_s[i] >> 1;
				dot_s[i+1]  <= dot_s[i];
				dq_s[i+1]   <= dq_s[i];
				dn_s[i+1]   <= dn_s[i];
				col_s[i+1]  <= col_s[i];
			end
		end
	end

	// intensity division
	logic [RW-1:0]     len;
	logic [DW-2:0]     dvd;
	logic [RW-1:0]     dvs;
	logic              iv;
	logic [QUOT_W-1:0] inten;
	logic [SIDE_W-1:0] side_out;

	assign len = root_s[RW][RW-1:0];
	assign dvd = (dot_s[RW] > 0 && len != '0) ? dot_s[RW][DW-2:0] : '0;
	assign dvs = (len == '0) ? RW'(1) : len;

	tcfs_div #(
		.DDW    (DW - 1),
		.VW     (RW),
		.QW     (QUOT_W),
		.SIDE_W (SIDE_W)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (sv_s[RW]),
		.dividend  (dvd),
		.divisor   (dvs),
		.side      ({col_s[RW], dn_s[RW], dq_s[RW]}),
		.out_valid (iv),
		.quotient  (inten),
		.side_out  (side_out)
	);

	// s9: shade
	logic                    v_s9;
	logic [SHW-1:0]          shade_s9;
	logic [2:0][COLOR_W-1:0] col_s9;
	logic                    dneg_s9;
	logic [DMW-1:0]          dq_s9;

	always_ff @(posedge clk) begin
		if (en) begin
			shade_s9 <= (SHW'(amb_q) << INTEN_FRAC) + SHW'(gain_q) * SHW'(inten);
			{col_s9, dneg_s9, dq_s9} <= side_out;
		end
	end

	// s10: channel products, signed depth
	logic                   v_s10;
	logic [PRW-1:0]         prod_s10 [3];
	logic [COORD_WIDTH-1:0] depth_s10;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				prod_s10[k] <= PRW'(col_s9[k]) * PRW'(shade_s9);
			end
			depth_s10 <= dneg_s9 ? COORD_WIDTH'(-dq_s9) : COORD_WIDTH'(dq_s9);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
		end else if (en) begin
			v_s9  <= iv;
			v_s10 <= v_s9;
		end
	end

	// saturation and output with skid entry
	logic [COLOR_W-1:0] chan [3];
	res_t               fin;
	res_t               out_q;
	res_t               skid_q;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			chan[k] = |prod_s10[k][PRW-1:SHADE_SHIFT+COLOR_W] ? '1 :
				prod_s10[k][SHADE_SHIFT +: COLOR_W];
		end
		fin.red   = chan[2];
		fin.green = chan[1];
		fin.blue  = chan[0];
		fin.depth = depth_s10;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (res_ready) begin
				skid_v_q <= 1'b0;
			end
		end else if (v_s10) begin
			if (!out_v_q || res_ready) begin
				out_v_q <= 1'b1;
			end else begin
				skid_v_q <= 1'b1;
			end
		end else if (res_ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (res_ready) begin
				out_q <= skid_q;
			end
		end else if (v_s10) begin
			if (!out_v_q || res_ready) begin
				out_q <= fin;
			end else begin
				skid_q <= fin;
			end
		end
	end

	assign res_valid  = out_v_q;
	assign lit_red    = out_q.red;
	assign lit_green  = out_q.green;
	assign lit_blue   = out_q.blue;
	assign mean_depth = out_q.depth;

endmodule

### rtl/core/tcfs_div.sv
module tcfs_div #(
	parameter int DDW    = 48,
	parameter int VW     = 31,
	parameter int QW     = 17,
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [DDW-1:0]    dividend,
	input  logic [VW-1:0]     divisor,
	input  logic [SIDE_W-1:0] side,
	output logic              out_valid,
	output logic [QW-1:0]     quotient,
	output logic [SIDE_W-1:0] side_out
);

	localparam int XW = (DDW > VW + QW) ? DDW : VW + QW;

	logic              v_s   [QW+1];
	logic [DDW-1:0]    rem_s [QW+1];
	logic [VW-1:0]     dv_s  [QW+1];
	logic [QW-1:0]     q_s   [QW+1];
	logic [SIDE_W-1:0] sd_s  [QW+1];

	assign v_s[0]   = in_valid;
	assign rem_s[0] = dividend;
	assign dv_s[0]  = divisor;
	assign q_s[0]   = '0;
	assign sd_s[0]  = side;

	for (genvar j = 0; j < QW; j++) begin : g_stage
		localparam int SH = QW - 1 - j;
		logic [XW-1:0] trial;
		logic          ge;

		assign trial = XW'(dv_s[j]) << SH;
		assign ge    = XW'(rem_s[j]) >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[j+1] <= 1'b0;
			end else if (en) begin
				v_s[j+1] <= v_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j+1] <= ge ? DDW'(XW'(rem_s[j]) - trial) : rem_s[j];
				dv_s[j+1]  <= dv_s[j];
				q_s[j+1]   <= {q_s[j][QW-2:0], ge};
				sd_s[j+1]  <= sd_s[j];
			end
		end
	end

	assign out_valid = v_s[QW];
	assign quotient  = q_s[QW];
	assign side_out  = sd_s[QW];

endmodule

### rtl/core/tcfs_checker.sv
module tcfs_checker #(
	parameter int COORD_WIDTH = 16
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         tri_ready,
	input logic                         res_valid,
	input logic                         res_ready,
	input logic [tcfs_pkg::COLOR_W-1:0] lit_red,
	input logic [tcfs_pkg::COLOR_W-1:0] lit_green,
	input logic [tcfs_pkg::COLOR_W-1:0] lit_blue,
	input logic [COORD_WIDTH-1:0]       mean_depth
);

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid &&
			$stable({lit_red, lit_green, lit_blue, mean_depth}))
		else $error("result changed while stalled");

	a_res_drop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(res_valid) |-> $past(res_ready))
		else $error("result dropped without being taken");

	a_busy_full: assert property (@(posedge clk) disable iff (!arst_n)
		!tri_ready |-> res_valid)
		else $error("request blocked with no result pending");

	a_busy_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!tri_ready |-> $past(res_valid && !res_ready))
		else $error("request blocked without an output stall");

endmodule

bind triangle_cull_and_flat_shade tcfs_checker #(
	.COORD_WIDTH (COORD_WIDTH)
) u_tcfs_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.tri_ready  (tri_ready),
	.res_valid  (res_valid),
	.res_ready  (res_ready),
	.lit_red    (lit_red),
	.lit_green  (lit_green),
	.lit_blue   (lit_blue),
	.mean_depth (mean_depth)
);
